FILE: src/tli_pkg.sv
package tli_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 9;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD_MASS = 1'b0,
    CFG_ENTRIES_IN_USE = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_INTERP  = 3'd0,
    ST_EXACT   = 3'd1,
    ST_OUTSIDE = 3'd2,
    ST_BELOW   = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

endpackage

FILE: src/table_linear_interpolator.sv
// Load: writes one entry, no result. Query: empty table or below threshold
// goes straight to the response; outside or an end point, after the last and
// first entries are read; else the scan walks up to an exact hit, or on
// through subtract, multiply, 32-step divider and output. One item in flight;
// a held result stalls the input. Synchronous active-low reset clears control
// state and both registers; table contents are undefined until loaded.
module table_linear_interpolator
  import tli_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [7:0]           in_load_index,
  input  logic [WORD_W-1:0]    in_load_energy,
  input  logic [WORD_W-1:0]    in_load_flux,
  input  logic [WORD_W-1:0]    in_query_energy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_W-1:0]    out_flux_out,
  output logic [2:0]           out_query_status,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_LAST, S_FIRST, S_SCAN, S_SUB, S_MUL, S_DIV_GO, S_DIV_WAIT, S_RESP
  } state_t;

  state_t              state_r;
  logic [WORD_W-1:0]   threshold_r;
  logic [COUNT_W-1:0]  entries_r;

  logic [WORD_W-1:0]   q_r;
  logic [WORD_W-1:0]   elast_r, wlast_r;
  logic [WORD_W-1:0]   e0_r, w0_r, e1_r, w1_r;
  logic [AW-1:0]       idx_r;
  logic [WORD_W-1:0]   dq_r, de_r, dw_r;
  logic                neg_r;
  logic [2*WORD_W-1:0] prod_r;
  logic [WORD_W-1:0]   res_flux_r;
  status_t             res_status_r;

  logic                out_valid_r;
  logic [WORD_W-1:0]   out_flux_r;
  logic [2:0]          out_status_r;

  logic [31:0]         n_full;
  logic [31:0]         last_full;
  logic [AW+7:0]       load_idx_ext;
  logic                load_ok;
  logic                accept;
  logic                ram_we;
  logic [AW-1:0]       rd_addr;
  logic [2*WORD_W-1:0] rdata;
  logic [WORD_W-1:0]   rd_e, rd_w;
  logic                div_start;
  logic                div_done;
  logic [WORD_W-1:0]   div_quo;
  logic                out_free;

  assign n_full    = (32'(entries_r) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                        : 32'(entries_r);
  assign last_full = n_full - 32'd1;

  assign load_idx_ext = {{AW{1'b0}}, in_load_index};
  assign load_ok      = 32'(in_load_index) < 32'(TABLE_DEPTH);

  assign in_ready  = state_r == S_IDLE;
  assign accept    = in_valid && in_ready;
  assign ram_we    = accept && (in_func == FUNC_LOAD) && load_ok;
  assign rd_e      = rdata[2*WORD_W-1:WORD_W];
  assign rd_w      = rdata[WORD_W-1:0];
  assign div_start = state_r == S_DIV_GO;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = last_full[AW-1:0];
      S_LAST:  rd_addr = '0;
      S_FIRST: rd_addr = AW'(1);
      S_SCAN:  rd_addr = idx_r + AW'(1);
      default: rd_addr = '0;
    endcase
  end

  tli_ram #(
    .WIDTH (2*WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_idx_ext[AW-1:0]),
    .wdata ({in_load_energy, in_load_flux}),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  tli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (de_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      entries_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_THRESHOLD_MASS: threshold_r <= cfg_data;
        CFG_ENTRIES_IN_USE: entries_r   <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && in_func == FUNC_QUERY) begin
            q_r <= in_query_energy;
            if (entries_r == '0) begin
              res_flux_r   <= '0;
              res_status_r <= ST_EMPTY;
              state_r      <= S_RESP;
            end else if (in_query_energy < threshold_r) begin
              res_flux_r   <= '0;
              res_status_r <= ST_BELOW;
              state_r      <= S_RESP;
            end else begin
              state_r <= S_LAST;
            end
          end
        end
        S_LAST: begin
          elast_r <= rd_e;
          wlast_r <= rd_w;
          state_r <= S_FIRST;
        end
        S_FIRST: begin
          e0_r  <= rd_e;
          w0_r  <= rd_w;
          idx_r <= AW'(1);
          if (q_r > elast_r || q_r < rd_e) begin
            res_flux_r   <= '0;
            res_status_r <= ST_OUTSIDE;
            state_r      <= S_RESP;
          end else if (rd_e == q_r) begin
            res_flux_r   <= rd_w;
            res_status_r <= ST_EXACT;
            state_r      <= S_RESP;
          end else if (elast_r == q_r) begin
            res_flux_r   <= wlast_r;
            res_status_r <= ST_EXACT;
            state_r      <= S_RESP;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_e == q_r) begin
            res_flux_r   <= rd_w;
            res_status_r <= ST_EXACT;
            state_r      <= S_RESP;
          end else if (rd_e > q_r) begin
            e1_r    <= rd_e;
            w1_r    <= rd_w;
            state_r <= S_SUB;
          end else begin
            e0_r  <= rd_e;
            w0_r  <= rd_w;
            idx_r <= idx_r + AW'(1);
          end
        end
        S_SUB: begin
          dq_r    <= q_r - e0_r;
          de_r    <= e1_r - e0_r;
          neg_r   <= w1_r < w0_r;
          dw_r    <= (w1_r < w0_r) ? (w0_r - w1_r) : (w1_r - w0_r);
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= (2*WORD_W)'(dw_r) * (2*WORD_W)'(dq_r);
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            res_flux_r   <= neg_r ? (w0_r - div_quo) : (w0_r + div_quo);
            res_status_r <= ST_INTERP;
            state_r      <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_flux_r   <= res_flux_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_flux_out     = out_flux_r;
  assign out_query_status = out_status_r;

endmodule

FILE: src/tli_ram.sv
module tli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/tli_div.sv
// Restoring divider, one quotient bit per cycle. Dividend high half must be
// below the divisor, so the quotient fits one word.
module tli_div
  import tli_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2*WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0]   divisor,
  output logic                done,
  output logic [WORD_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] dvs_r;
  logic [WORD_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, quo_r[WORD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= dividend[2*WORD_W-1:WORD_W];
        quo_r  <= dividend[WORD_W-1:0];
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? WORD_W'(trial - {1'b0, dvs_r}) : trial[WORD_W-1:0];
        quo_r <= {quo_r[WORD_W-2:0], fits};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: dv/table_linear_interpolator_test.sv
`timescale 1ns / 100ps

module table_linear_interpolator_test;
  import tli_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int TARGET_OPS = 1320;
  localparam int CALM_AFTER = 1180;

  typedef struct {
    func_t       func;
    logic [7:0]  index;
    logic [31:0] energy;
    logic [31:0] flux;
    logic [31:0] query;
  } table_op_t;

  typedef struct packed {
    logic [31:0] flux;
    status_t     status;
  } flux_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic [7:0] in_load_index = '0;
  logic [WORD_W-1:0] in_load_energy = '0;
  logic [WORD_W-1:0] in_load_flux = '0;
  logic [WORD_W-1:0] in_query_energy = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WORD_W-1:0] out_flux_out;
  logic [2:0] out_query_status;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0] cfg_data = '0;

  table_linear_interpolator #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_load_index   (in_load_index),
    .in_load_energy  (in_load_energy),
    .in_load_flux    (in_load_flux),
    .in_query_energy (in_query_energy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_flux_out    (out_flux_out),
    .out_query_status(out_query_status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // predicted block state
  logic [31:0] model_e [TABLE_DEPTH];
  logic [31:0] model_f [TABLE_DEPTH];
  logic [31:0] model_thr = '0;
  logic [8:0]  model_count = '0;

  // table as the stimulus will leave it, for aiming queries
  logic [31:0] gen_e [TABLE_DEPTH];
  logic [31:0] gen_f [TABLE_DEPTH];

  table_op_t    pending_ops [$];
  table_op_t    active_op;
  flux_result_t flux_expect [$];
  flux_result_t want;

  int ops_pushed = 0;
  int ops_accepted = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int mismatches = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  function automatic logic [31:0] interp_flux(logic [31:0] e0, logic [31:0] w0,
                                              logic [31:0] e1, logic [31:0] w1,
                                              logic [31:0] q);
    logic [63:0] dq, de, dw, stepv;
    dq = {32'd0, q - e0};
    de = {32'd0, e1 - e0};
    if (de == 0) return w0;
    if (w1 >= w0) begin
      dw = {32'd0, w1 - w0};
      stepv = (dw * dq) / de;
      return w0 + stepv[31:0];
    end
    dw = {32'd0, w0 - w1};
    stepv = (dw * dq) / de;
    return w0 - stepv[31:0];
  endfunction

  function automatic flux_result_t predict_flux(logic [31:0] q);
    flux_result_t r;
    int unsigned n, last;
    bit hit;
    n = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
    r.flux = '0;
    r.status = ST_OUTSIDE;
    hit = 1'b0;
    if (n == 0) begin
      r.status = ST_EMPTY;
    end else if (q < model_thr) begin
      r.status = ST_BELOW;
    end else begin
      last = n - 1;
      if (q > model_e[last] || q < model_e[0]) begin
        r.status = ST_OUTSIDE;
      end else if (model_e[0] == q) begin
        r.flux = model_f[0];
        r.status = ST_EXACT;
      end else if (model_e[last] == q) begin
        r.flux = model_f[last];
        r.status = ST_EXACT;
      end else begin
        for (int i = 1; i < n && !hit; i++) begin
          if (model_e[i] == q) begin
            r.flux = model_f[i];
            r.status = ST_EXACT;
            hit = 1'b1;
          end else if (model_e[i] > q) begin
            r.flux = interp_flux(model_e[i-1], model_f[i-1], model_e[i], model_f[i], q);
            r.status = ST_INTERP;
            hit = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_query(int unsigned n);
    int unsigned i;
    if (n == 0) return $urandom;
    case ($urandom_range(0, 9))
      0, 1: return gen_e[$urandom_range(0, n - 1)];
      2, 3, 4: begin
        i = (n > 1) ? $urandom_range(0, n - 2) : 0;
        return $urandom_range(gen_e[i], gen_e[(n > 1) ? i + 1 : i]);
      end
      5: return (gen_e[0] == 0) ? 32'h0 : $urandom_range(0, gen_e[0] - 1);
      6: return (gen_e[n-1] == '1) ? 32'hFFFF_FFFF :
                $urandom_range(gen_e[n-1] + 1, 32'hFFFF_FFFF);
      7: return model_thr + $urandom_range(0, 2) - 1;
      8: return $urandom;
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  task automatic push_load(logic [7:0] idx, logic [31:0] e, logic [31:0] f);
    table_op_t op;
    op.func = FUNC_LOAD;
    op.index = idx;
    op.energy = e;
    op.flux = f;
    op.query = $urandom;
    gen_e[idx] = e;
    gen_f[idx] = f;
    pending_ops.insert(pending_ops.size(), op);
    ops_pushed++;
  endtask

  task automatic push_query(logic [31:0] q);
    table_op_t op;
    op.func = FUNC_QUERY;
    op.index = 8'($urandom);
    op.energy = $urandom;
    op.flux = $urandom;
    op.query = q;
    pending_ops.insert(pending_ops.size(), op);
    ops_pushed++;
  endtask

  task automatic fill_table(int unsigned n, bit ascending);
    logic [63:0] e, step_max;
    logic [31:0] f;
    e = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(0, 32'h7FFF_FFFF));
    step_max = (64'hFFFF_FFFF - e) / n;
    if ($urandom_range(0, 3) == 0 && step_max > 64) step_max = 64;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: f = '0;
        1: f = '1;
        default: f = $urandom;
      endcase
      push_load(i[7:0], ascending ? e[31:0] : 32'($urandom), f);
      e = e + $urandom_range(0, step_max[31:0]);
    end
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_THRESHOLD_MASS) model_thr = data;
    else model_count = data[8:0];
  endtask

  // sender holds back here until every transfer is taken and answered
  task automatic drain();
    while (ops_accepted != ops_pushed || flux_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        ops_accepted++;
        if (active_op.func == FUNC_LOAD) begin
          model_e[active_op.index] = active_op.energy;
          model_f[active_op.index] = active_op.flux;
        end else begin
          flux_expect.insert(flux_expect.size(), predict_flux(active_op.query));
        end
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          active_op = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_func <= active_op.func;
          in_load_index <= active_op.index;
          in_load_energy <= active_op.energy;
          in_load_flux <= active_op.flux;
          in_query_energy <= active_op.query;
          if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (flux_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: flux %h status %0d", out_flux_out, out_query_status);
        end else begin
          want = flux_expect.pop_front();
          if (out_flux_out !== want.flux || out_query_status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected flux %h status %0d, got flux %h status %0d",
                       want.flux, want.status, out_flux_out, out_query_status);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned n_cfg, eff, phase;
    logic [31:0] thr;
    logic [7:0] idx;
    phase = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty table straight after reset
    push_query(32'h0001_2345);
    push_load(8'd0, 32'h0001_0000, 32'h0000_0000);
    push_load(8'd1, 32'h0003_0000, 32'hFFFF_FFFF);
    push_load(8'd2, 32'h0005_0000, 32'h0000_8000);
    push_load(8'd3, 32'hFFFF_0000, 32'h1234_5678);
    push_load(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_query(32'h0);
    drain();

    cfg_write(CFG_THRESHOLD_MASS, 32'h0);
    cfg_write(CFG_ENTRIES_IN_USE, 32'd4);
    push_query(32'h0);
    push_query(32'hFFFF_FFFF);
    push_query(32'h0000_FFFF);
    push_query(32'hFFFF_0001);
    push_query(32'h0001_0000);
    push_query(32'hFFFF_0000);
    push_query(32'h0003_0000);
    push_query(32'h0002_0000);
    push_query(32'h0004_0000);
    push_query(32'h0800_0000);
    drain();

    // count register with junk above bit 8
    cfg_write(CFG_THRESHOLD_MASS, 32'h0004_0000);
    cfg_write(CFG_ENTRIES_IN_USE, 32'hFFFF_FE04);
    push_query(32'h0003_FFFF);
    push_query(32'h0004_0000);
    push_query(32'h0);
    push_query(32'h0005_0000);
    drain();

    cfg_write(CFG_THRESHOLD_MASS, 32'hFFFF_FFFF);
    cfg_write(CFG_ENTRIES_IN_USE, 32'hFFFF_FE00);
    push_query(32'hFFFF_FFFF);
    drain();
    cfg_write(CFG_ENTRIES_IN_USE, 32'd4);
    push_query(32'hFFFF_0000);
    push_query(32'hFFFF_FFFF);
    drain();

    // every entry written before any wider count is used
    cfg_write(CFG_ENTRIES_IN_USE, 32'd0);
    fill_table(TABLE_DEPTH, 1'b1);
    drain();

    while (ops_pushed < TARGET_OPS) begin
      if (ops_pushed > CALM_AFTER) calm = 1'b1;
      if (phase == 0) n_cfg = $urandom_range(257, 511);
      else if (phase == 1) n_cfg = TABLE_DEPTH;
      else begin
        case ($urandom_range(0, 19))
          0: n_cfg = 0;
          1: n_cfg = TABLE_DEPTH;
          2: n_cfg = $urandom_range(257, 511);
          3: n_cfg = 1;
          default: n_cfg = $urandom_range(2, 16);
        endcase
      end
      eff = (n_cfg > TABLE_DEPTH) ? TABLE_DEPTH : n_cfg;
      if (eff > 0 && (eff < TABLE_DEPTH || $urandom_range(0, 1) == 0)) begin
        fill_table(eff, $urandom_range(0, 4) != 0);
        drain();
      end

      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: thr = 32'h0;
        10, 11, 12, 13: thr = (eff > 0) ? gen_e[$urandom_range(0, eff - 1)] : 32'($urandom);
        14, 15, 16: thr = $urandom;
        17: thr = (eff > 0) ? gen_e[eff - 1] + 1 : 32'h0;
        default: thr = 32'hFFFF_FFFF;
      endcase
      cfg_write(CFG_THRESHOLD_MASS, thr);
      cfg_write(CFG_ENTRIES_IN_USE, ($urandom & 32'hFFFF_FE00) | n_cfg);

      repeat ($urandom_range(30, 60)) begin
        if ($urandom_range(0, 4) == 0) begin
          if (eff < TABLE_DEPTH && $urandom_range(0, 1) == 0)
            idx = 8'($urandom_range(eff, TABLE_DEPTH - 1));
          else
            idx = 8'($urandom);
          push_load(idx, $urandom, $urandom);
        end else begin
          push_query(pick_query(eff));
        end
      end
      drain();
      phase++;
    end

    drain();
    repeat (400) @(posedge clk);
    if (mismatches == 0 && flux_expect.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
